@@ design/mexp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int EXP_BITS  = 32;
    localparam int EXP_CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam int MOD_W     = 31;
    localparam int OPB_W     = 32;
    localparam int STEP_W    = $clog2(OPB_W);

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_BIT,
        S_MUL,
        S_SQR,
        S_OUT
    } t_state;

    // one request to the modular multiplier
    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] a;
        logic [OPB_W-1:0] b;
    } t_mm_req;

endpackage

@@ design/modular_exponentiation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// The slave stream takes one item: tdata[31:0] base, tdata[63:32] exponent.
// The master stream returns one item per input: tdata[30:0] the result.
// The cfg channel writes the modulus; it is always ready and must only be
// written while the block is idle. Reset sets the modulus to 1000000007.
// All arithmetic runs through one bit-serial modular multiplier, which
// signals each finished product with a done strobe. An item first reduces
// the base, then for each exponent bit multiplies the result by the square
// when the bit is set and then squares the square. A modulus of zero gives
// 0 in the cycle right after the accepting edge.
// s_tready is high only while idle; the result sits in an output register
// and the block waits there, not ready, until the master side takes it.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,   // base_value[31:0], exponent[63:32]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // power_result[30:0], zero pad
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [MOD_W-1:0] i_cfg_data
);

    t_state                r_state, n_state;
    logic [MOD_W-1:0]      r_mod;
    logic [EXP_BITS-1:0]   r_exp, n_exp;
    logic [EXP_CNT_W-1:0]  r_bit, n_bit;
    logic [MOD_W-1:0]      r_sq, n_sq;
    logic [MOD_W-1:0]      r_res, n_res;
    logic [MOD_W-1:0]      r_out, n_out;
    t_mm_req               mm_req;
    logic                  mm_done;
    logic [MOD_W-1:0]      mm_result;
    logic                  in_fire;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_RESET;
        end else if (i_cfg_valid) begin
            r_mod <= i_cfg_data;
        end
    end

    mexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mm_req),
        .i_mod    (r_mod),
        .o_done   (mm_done),
        .o_result (mm_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_bit <= n_bit;
        r_sq  <= n_sq;
        r_res <= n_res;
        r_out <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_exp    = r_exp;
        n_bit    = r_bit;
        n_sq     = r_sq;
        n_res    = r_res;
        n_out    = r_out;
        mm_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_exp = EXP_BITS'(s_axis_tdata[63:32]);
                    n_bit = '0;
                    if (r_mod == '0) begin
                        n_out   = '0;
                        n_state = S_OUT;
                    end else begin
                        // base mod m as 1 * base
                        mm_req.start = 1'b1;
                        mm_req.a     = MOD_W'(1);
                        mm_req.b     = s_axis_tdata[31:0];
                        n_state      = S_RED;
                    end
                end
            end
            S_RED: begin
                if (mm_done) begin
                    n_sq    = mm_result;
                    n_res   = (r_mod == MOD_W'(1)) ? '0 : MOD_W'(1);
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                mm_req.start = 1'b1;
                mm_req.b     = {1'b0, r_sq};
                if (r_exp[0]) begin
                    mm_req.a = r_res;
                    n_state  = S_MUL;
                end else begin
                    mm_req.a = r_sq;
                    n_state  = S_SQR;
                end
            end
            S_MUL: begin
                if (mm_done) begin
                    n_res        = mm_result;
                    mm_req.start = 1'b1;
                    mm_req.a     = r_sq;
                    mm_req.b     = {1'b0, r_sq};
                    n_state      = S_SQR;
                end
            end
            S_SQR: begin
                if (mm_done) begin
                    n_sq  = mm_result;
                    n_exp = r_exp >> 1;
                    n_bit = r_bit + 1'b1;
                    if (r_bit == EXP_CNT_W'(EXP_BITS - 1)) begin
                        n_out   = r_res;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_BIT;
                    end
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {1'b0, r_out};

endmodule

@@ design/mexp_mulmod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: a * b mod m, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mm_req          i_req,
    input  logic [MOD_W-1:0] i_mod,
    output logic             o_done,
    output logic [MOD_W-1:0] o_result
);

    logic [MOD_W-1:0]  r_acc, n_acc;
    logic [MOD_W-1:0]  r_a;
    logic [OPB_W-1:0]  r_b;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [MOD_W+1:0]  t_sum;
    logic [MOD_W+2:0]  t_sub1, t_sub2;

    // acc < m and a <= m, so 2*acc + a < 3m: subtract 0, m or 2m
    always_comb begin
        t_sum  = {1'b0, r_acc, 1'b0} + (r_b[OPB_W-1] ? {2'b00, r_a} : '0);
        t_sub1 = {1'b0, t_sum} - {3'b000, i_mod};
        t_sub2 = {1'b0, t_sum} - {2'b00, i_mod, 1'b0};
        if (!t_sub2[MOD_W+2]) begin
            n_acc = t_sub2[MOD_W-1:0];
        end else if (!t_sub1[MOD_W+2]) begin
            n_acc = t_sub1[MOD_W-1:0];
        end else begin
            n_acc = t_sum[MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(OPB_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[OPB_W-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

@@ design/mexp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker
    import mexp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time: no new item right after one is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accepting an item");

    // never ready for input while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // result is below 2^31
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[31])
        else $error("pad bit set in result");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
